FILE: rtl/psimd_pkg.sv
// Shared types, operation codes and lane functions for the packed-integer SIMD unit.
// No dependencies; psimd_alu and the top level import this package.

package psimd_pkg;

    localparam int NUM_VEC_REGS_DEF = 16;

    typedef enum logic [4:0] {
        OP_MOV   = 5'd0,
        OP_XOR   = 5'd1,
        OP_AND   = 5'd2,
        OP_OR    = 5'd3,
        OP_ADDB  = 5'd4,
        OP_ADDW  = 5'd5,
        OP_ADDD  = 5'd6,
        OP_ADDQ  = 5'd7,
        OP_SUBB  = 5'd8,
        OP_SUBW  = 5'd9,
        OP_SUBD  = 5'd10,
        OP_SUBQ  = 5'd11,
        OP_SHUF  = 5'd12,
        OP_CMPB  = 5'd13,
        OP_CMPW  = 5'd14,
        OP_CMPD  = 5'd15,
        OP_SCIN  = 5'd16,
        OP_SCOUT = 5'd17,
        OP_LOW64 = 5'd18
    } t_op;

    typedef enum logic [1:0] {
        LSZ_B = 2'd0,
        LSZ_W = 2'd1,
        LSZ_D = 2'd2,
        LSZ_Q = 2'd3
    } t_lsz;

    typedef struct packed {
        logic [4:0]  op;
        logic [3:0]  dst_reg;
        logic [3:0]  src_reg;
        logic        src_from_mem;
        logic [63:0] mem_lo;
        logic [63:0] mem_hi;
        logic [7:0]  shuffle_ctrl;
        logic [63:0] scalar_in;
        logic        wide;
        logic        dst_to_mem;
    } t_req;

    typedef struct packed {
        logic [63:0] value_lo;
        logic [63:0] value_hi;
        logic        wr;
    } t_alu_res;

    // Byte-wise ripple with the carry cut at every lane boundary
    function automatic logic [63:0] lanes_arith(input logic [63:0] a, input logic [63:0] b,
                                                input logic sub, input t_lsz sz);
        logic [63:0] bb;
        logic [63:0] r;
        logic [8:0]  s;
        logic        c;
        logic [2:0]  lmask;
        logic        start;
        bb = sub ? ~b : b;
        c  = 1'b0;
        r  = '0;
        case (sz)
            LSZ_B:   lmask = 3'b000;
            LSZ_W:   lmask = 3'b001;
            LSZ_D:   lmask = 3'b011;
            default: lmask = 3'b111;
        endcase
        for (int k = 0; k < 8; k++) begin
            start = ((3'(k) & lmask) == 3'b000);
            s = {1'b0, a[8*k +: 8]} + {1'b0, bb[8*k +: 8]} + {8'b0, (start ? sub : c)};
            r[8*k +: 8] = s[7:0];
            c = s[8];
        end
        return r;
    endfunction

    function automatic logic [63:0] lanes_eq(input logic [63:0] a, input logic [63:0] b,
                                             input t_lsz sz);
        logic [7:0]  e;
        logic [3:0]  e16;
        logic [1:0]  e32;
        logic [63:0] r;
        logic        hit;
        for (int k = 0; k < 8; k++) begin
            e[k] = (a[8*k +: 8] == b[8*k +: 8]);
        end
        for (int j = 0; j < 4; j++) begin
            e16[j] = e[2*j] & e[2*j+1];
        end
        for (int j = 0; j < 2; j++) begin
            e32[j] = &e[4*j +: 4];
        end
        r = '0;
        for (int k = 0; k < 8; k++) begin
            case (sz)
                LSZ_B:   hit = e[k];
                LSZ_W:   hit = e16[k/2];
                default: hit = e32[k/4];
            endcase
            r[8*k +: 8] = {8{hit}};
        end
        return r;
    endfunction

    function automatic logic [31:0] pick32(input logic [127:0] v, input logic [1:0] sel);
        return v[32*sel +: 32];
    endfunction

endpackage

FILE: rtl/psimd_if.sv
// Request and result channels of the packed-integer SIMD unit.
// Valid/ready handshake; no dependencies.

interface psimd_in_if;
    logic        valid;
    logic        ready;
    logic [4:0]  op;
    logic [3:0]  dst_reg;
    logic [3:0]  src_reg;
    logic        src_from_mem;
    logic [63:0] mem_lo;
    logic [63:0] mem_hi;
    logic [7:0]  shuffle_ctrl;
    logic [63:0] scalar_in;
    logic        wide;
    logic        dst_to_mem;

    modport source (output valid, op, dst_reg, src_reg, src_from_mem, mem_lo, mem_hi,
                    shuffle_ctrl, scalar_in, wide, dst_to_mem, input ready);
    modport sink   (input valid, op, dst_reg, src_reg, src_from_mem, mem_lo, mem_hi,
                    shuffle_ctrl, scalar_in, wide, dst_to_mem, output ready);
endinterface

interface psimd_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] value_lo;
    logic [63:0] value_hi;
    logic        to_register;

    modport source (output valid, value_lo, value_hi, to_register, input ready);
    modport sink   (input valid, value_lo, value_hi, to_register, output ready);
endinterface

FILE: rtl/psimd_rf.sv
// Vector register file: two 64-bit half memories, two read ports, one write port.
// Per-entry valid bits give the all-zero reset value. Depends on nothing else.

module psimd_rf #(
    parameter int NUM_VEC_REGS = 16,
    parameter int AW           = $clog2(NUM_VEC_REGS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_a,
    input  logic [AW-1:0] i_rd_b,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [63:0]   i_wr_lo,
    input  logic [63:0]   i_wr_hi,
    output logic [63:0]   o_a_lo,
    output logic [63:0]   o_a_hi,
    output logic [63:0]   o_b_lo,
    output logic [63:0]   o_b_hi
);

    logic [63:0] mem_lo [NUM_VEC_REGS];
    logic [63:0] mem_hi [NUM_VEC_REGS];

    logic [NUM_VEC_REGS-1:0] r_vld;
    logic        r_a_vld;
    logic        r_b_vld;
    logic [63:0] r_a_lo;
    logic [63:0] r_a_hi;
    logic [63:0] r_b_lo;
    logic [63:0] r_b_hi;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem_lo[i_wr_addr] <= i_wr_lo;
            mem_hi[i_wr_addr] <= i_wr_hi;
        end
        if (i_rd_en) begin
            r_a_lo <= mem_lo[i_rd_a];
            r_a_hi <= mem_hi[i_rd_a];
            r_b_lo <= mem_lo[i_rd_b];
            r_b_hi <= mem_hi[i_rd_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_a_vld <= r_vld[i_rd_a];
                r_b_vld <= r_vld[i_rd_b];
            end
        end
    end

    // Never-written entries read as zero
    assign o_a_lo = r_a_vld ? r_a_lo : '0;
    assign o_a_hi = r_a_vld ? r_a_hi : '0;
    assign o_b_lo = r_b_vld ? r_b_lo : '0;
    assign o_b_hi = r_b_vld ? r_b_hi : '0;

endmodule

FILE: rtl/psimd_alu.sv
// Lane datapath: logic ops, lane add/sub/compare, shuffle and scalar moves.
// Uses psimd_pkg for operation codes and lane functions.

module psimd_alu (
    input  psimd_pkg::t_req     i_req,
    input  logic [63:0]         i_a_lo,
    input  logic [63:0]         i_a_hi,
    input  logic [63:0]         i_breg_lo,
    input  logic [63:0]         i_breg_hi,
    output psimd_pkg::t_alu_res o_res
);
    import psimd_pkg::*;

    logic [63:0]  b_lo;
    logic [63:0]  b_hi;
    logic [127:0] b_all;
    t_lsz         sz;

    assign b_lo  = i_req.src_from_mem ? i_req.mem_lo : i_breg_lo;
    assign b_hi  = i_req.src_from_mem ? i_req.mem_hi : i_breg_hi;
    assign b_all = {b_hi, b_lo};
    assign sz    = t_lsz'(i_req.op[1:0]);

    always_comb begin
        o_res = '0;
        o_res.wr = 1'b1;
        case (t_op'(i_req.op))
            OP_MOV: begin
                o_res.value_lo = b_lo;
                o_res.value_hi = b_hi;
                o_res.wr       = !i_req.dst_to_mem;
            end
            OP_XOR: begin
                o_res.value_lo = i_a_lo ^ b_lo;
                o_res.value_hi = i_a_hi ^ b_hi;
            end
            OP_AND: begin
                o_res.value_lo = i_a_lo & b_lo;
                o_res.value_hi = i_a_hi & b_hi;
            end
            OP_OR: begin
                o_res.value_lo = i_a_lo | b_lo;
                o_res.value_hi = i_a_hi | b_hi;
            end
            OP_ADDB, OP_ADDW, OP_ADDD, OP_ADDQ: begin
                o_res.value_lo = lanes_arith(i_a_lo, b_lo, 1'b0, sz);
                o_res.value_hi = lanes_arith(i_a_hi, b_hi, 1'b0, sz);
            end
            OP_SUBB, OP_SUBW, OP_SUBD, OP_SUBQ: begin
                o_res.value_lo = lanes_arith(i_a_lo, b_lo, 1'b1, sz);
                o_res.value_hi = lanes_arith(i_a_hi, b_hi, 1'b1, sz);
            end
            OP_SHUF: begin
                o_res.value_lo = {pick32(b_all, i_req.shuffle_ctrl[3:2]),
                                  pick32(b_all, i_req.shuffle_ctrl[1:0])};
                o_res.value_hi = {pick32(b_all, i_req.shuffle_ctrl[7:6]),
                                  pick32(b_all, i_req.shuffle_ctrl[5:4])};
            end
            OP_CMPB: begin
                o_res.value_lo = lanes_eq(i_a_lo, b_lo, LSZ_B);
                o_res.value_hi = lanes_eq(i_a_hi, b_hi, LSZ_B);
            end
            OP_CMPW: begin
                o_res.value_lo = lanes_eq(i_a_lo, b_lo, LSZ_W);
                o_res.value_hi = lanes_eq(i_a_hi, b_hi, LSZ_W);
            end
            OP_CMPD: begin
                o_res.value_lo = lanes_eq(i_a_lo, b_lo, LSZ_D);
                o_res.value_hi = lanes_eq(i_a_hi, b_hi, LSZ_D);
            end
            OP_SCIN: begin
                o_res.value_lo = i_req.wide ? i_req.scalar_in : {32'b0, i_req.scalar_in[31:0]};
            end
            OP_SCOUT: begin
                // Always from the register, whatever the memory flag says
                o_res.value_lo = i_req.wide ? i_breg_lo : {32'b0, i_breg_lo[31:0]};
                o_res.wr       = 1'b0;
            end
            OP_LOW64: begin
                o_res.value_lo = b_lo;
            end
            default: begin
                o_res.wr = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/packed_integer_simd_unit.sv
// Packed-integer SIMD unit top level: request capture, register file, lane datapath, result register.
// Depends on psimd_pkg, psimd_if, psimd_rf and psimd_alu.
//
//   channel | dir | handshake     | carries
//   i_in    | in  | valid / ready | one instruction and its memory/scalar operands
//   o_out   | out | valid / ready | value_lo, value_hi, to_register
//
// The accept cycle issues the register-file read; the execute state computes on the registered
// read data and writes back once the output register is free. The registered memory read and
// the write back before the next read mean a new request is only taken after the last one's write back.
// Reset clears the valid bits of the register file at once; there is no clearing pass.
// A result waits in the output register; a request already read waits there until it frees.

module packed_integer_simd_unit #(
    parameter int NUM_VEC_REGS = psimd_pkg::NUM_VEC_REGS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    psimd_in_if.sink     i_in,
    psimd_out_if.source  o_out
);
    import psimd_pkg::*;

    localparam int AW = $clog2(NUM_VEC_REGS);
    localparam logic [5:0] NREG6 = 6'(NUM_VEC_REGS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state      r_state;
    t_state      n_state;
    t_req        r_req;
    logic [AW-1:0] r_dst;
    logic        r_out_vld;
    logic [63:0] r_out_lo;
    logic [63:0] r_out_hi;
    logic        r_out_to_reg;

    logic        accept;
    logic        fire;
    logic [AW-1:0] rd_a;
    logic [AW-1:0] rd_b;
    logic [63:0] a_lo;
    logic [63:0] a_hi;
    logic [63:0] breg_lo;
    logic [63:0] breg_hi;
    t_alu_res    res;

    // Register number modulo the file depth; the 4-bit number is below twice the depth
    function automatic logic [AW-1:0] reg_idx(input logic [3:0] r);
        logic [5:0] x;
        x = {2'b00, r};
        if (x >= NREG6) begin
            x = x - NREG6;
        end
        return AW'(x);
    endfunction

    assign i_in.ready = (r_state == ST_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign fire       = (r_state == ST_EXEC) && (!r_out_vld || o_out.ready);
    assign rd_a       = reg_idx(i_in.dst_reg);
    assign rd_b       = reg_idx(i_in.src_reg);

    psimd_rf #(
        .NUM_VEC_REGS (NUM_VEC_REGS),
        .AW           (AW)
    ) u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_a    (rd_a),
        .i_rd_b    (rd_b),
        .i_wr_en   (fire && res.wr),
        .i_wr_addr (r_dst),
        .i_wr_lo   (res.value_lo),
        .i_wr_hi   (res.value_hi),
        .o_a_lo    (a_lo),
        .o_a_hi    (a_hi),
        .o_b_lo    (breg_lo),
        .o_b_hi    (breg_hi)
    );

    psimd_alu u_alu (
        .i_req     (r_req),
        .i_a_lo    (a_lo),
        .i_a_hi    (a_hi),
        .i_breg_lo (breg_lo),
        .i_breg_hi (breg_hi),
        .o_res     (res)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (fire) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: capture the request, load the result
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op           <= i_in.op;
            r_req.dst_reg      <= i_in.dst_reg;
            r_req.src_reg      <= i_in.src_reg;
            r_req.src_from_mem <= i_in.src_from_mem;
            r_req.mem_lo       <= i_in.mem_lo;
            r_req.mem_hi       <= i_in.mem_hi;
            r_req.shuffle_ctrl <= i_in.shuffle_ctrl;
            r_req.scalar_in    <= i_in.scalar_in;
            r_req.wide         <= i_in.wide;
            r_req.dst_to_mem   <= i_in.dst_to_mem;
            r_dst              <= rd_a;
        end
        if (fire) begin
            r_out_lo     <= res.value_lo;
            r_out_hi     <= res.value_hi;
            r_out_to_reg <= res.wr;
        end
    end

    assign o_out.valid       = r_out_vld;
    assign o_out.value_lo    = r_out_lo;
    assign o_out.value_hi    = r_out_hi;
    assign o_out.to_register = r_out_to_reg;

endmodule

FILE: rtl/psimd_chk.sv
// Port-level checks for the packed-integer SIMD unit, bound to the top level.
// Depends on packed_integer_simd_unit and its channel interfaces.

module psimd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_lo,
    input logic [63:0] i_out_hi,
    input logic        i_out_to_reg
);

    // A held result keeps its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_lo) &&
            $stable(i_out_hi) && $stable(i_out_to_reg))
        else $error("result changed while stalled");

    // One request in flight: ready drops right after an accept
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted while another is in flight");

    // Ready only drops because a request was taken
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid))
        else $error("ready dropped without a request");

    // A fresh result traces back to an accepted request, through the register-file read and the result register
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("result without a matching request");

endmodule

bind packed_integer_simd_unit psimd_chk u_psimd_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_lo     (o_out.value_lo),
    .i_out_hi     (o_out.value_hi),
    .i_out_to_reg (o_out.to_register)
);
